// ===== hw/rtl/pcc_pkg.sv =====
// Package for the clamped PID controller: widths, reset values, register
// indexes, sequencer states and the status struct of the serial units.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int FRAC_BITS       = 16;
   localparam int GAIN_WIDTH      = 32;
   localparam int ACCUM_WIDTH     = 48;
   localparam int ERR_WIDTH       = SAMPLE_WIDTH + 1;
   localparam int STEP_WIDTH      = FRAC_BITS;
   localparam int DIFF_WIDTH      = ERR_WIDTH + 1;
   localparam int MAG_WIDTH       = ERR_WIDTH;
   localparam int DIVIDEND_WIDTH  = MAG_WIDTH + FRAC_BITS;
   localparam int DERIV_WIDTH     = 32;
   localparam int MCAND_WIDTH     = ACCUM_WIDTH;
   localparam int MPLIER_WIDTH    = GAIN_WIDTH;
   localparam int PROD_WIDTH      = MCAND_WIDTH + MPLIER_WIDTH;
   localparam int INC_WIDTH       = ACCUM_WIDTH + 1;
   localparam int PROP_WIDTH      = ERR_WIDTH + GAIN_WIDTH;
   localparam int SAT_WIDTH       = 64;
   localparam int TOTAL_WIDTH     = SAT_WIDTH + 2;
   localparam int QUOT_WIDTH      = SAT_WIDTH - FRAC_BITS;
   localparam int MUL_CNT_WIDTH   = $clog2(MPLIER_WIDTH);
   localparam int DIV_CNT_WIDTH   = $clog2(DIVIDEND_WIDTH);
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = ACCUM_WIDTH;

   localparam logic [SAMPLE_WIDTH-1:0] DRIVE_LOWER_RESET = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic [SAMPLE_WIDTH-1:0] DRIVE_UPPER_RESET = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic [ACCUM_WIDTH-1:0]  ACCUM_LOWER_RESET = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};
   localparam logic [ACCUM_WIDTH-1:0]  ACCUM_UPPER_RESET = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_GAIN_PROP   = 3'd0,
      CSR_GAIN_INTEG  = 3'd1,
      CSR_GAIN_DERIV  = 3'd2,
      CSR_DRIVE_LOWER = 3'd3,
      CSR_DRIVE_UPPER = 3'd4,
      CSR_ACCUM_LOWER = 3'd5,
      CSR_ACCUM_UPPER = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRE,
      ST_INC,
      ST_PROP,
      ST_INTEG,
      ST_DWAIT,
      ST_DERIV,
      ST_ROUND,
      ST_LIMIT
   } pid_state_type;

   // Status of a serial arithmetic unit: busy while stepping, done for the
   // one cycle in which the result is first valid.
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pcc_mul.sv =====
// Radix-2 shift-add signed multiplier, one multiplier bit per cycle.
// Depends on pcc_pkg for operand widths and the unit status struct.
`timescale 1ns / 1ps
`default_nettype none

module pcc_mul
   import pcc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     mul_start,
   input  wire logic [MCAND_WIDTH-1:0]   mul_mcand,
   input  wire logic [MPLIER_WIDTH-1:0]  mul_mplier,
   output logic      [PROD_WIDTH-1:0]    mul_prod,
   output unit_stat_type                 mul_stat
);

   localparam logic [MUL_CNT_WIDTH-1:0] LAST_STEP = MUL_CNT_WIDTH'(MPLIER_WIDTH - 1);

   logic [MCAND_WIDTH-1:0]   mcand_ff, mcand_in;
   logic [MCAND_WIDTH-1:0]   hi_ff, hi_in;
   logic [MPLIER_WIDTH-1:0]  lo_ff, lo_in;
   logic [MUL_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [MCAND_WIDTH:0]     hi_ext;
   logic [MCAND_WIDTH:0]     add_ext;
   logic [MCAND_WIDTH:0]     sum;
   logic                     last;

   always_comb begin
      last    = (cnt_ff == LAST_STEP);
      hi_ext  = {hi_ff[MCAND_WIDTH-1], hi_ff};
      add_ext = lo_ff[0] ? {mcand_ff[MCAND_WIDTH-1], mcand_ff} : '0;
      // The sign bit of the multiplier carries negative weight.
      sum     = last ? (hi_ext - add_ext) : (hi_ext + add_ext);

      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (mul_start) begin
         mcand_in = mul_mcand;
         hi_in    = '0;
         lo_in    = mul_mplier;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum[MCAND_WIDTH:1];
         lo_in  = {sum[0], lo_ff[MPLIER_WIDTH-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      cnt_ff   <= cnt_in;
   end

   assign mul_prod      = {hi_ff, lo_ff};
   assign mul_stat.busy = busy_ff;
   assign mul_stat.done = done_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pcc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pcc_pkg for operand widths and the unit status struct.
`timescale 1ns / 1ps
`default_nettype none

module pcc_div
   import pcc_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       div_start,
   input  wire logic [DIVIDEND_WIDTH-1:0]  div_dividend,
   input  wire logic [STEP_WIDTH-1:0]      div_divisor,
   output logic      [DIVIDEND_WIDTH-1:0]  div_quot,
   output unit_stat_type                   div_stat
);

   localparam logic [DIV_CNT_WIDTH-1:0] LAST_STEP = DIV_CNT_WIDTH'(DIVIDEND_WIDTH - 1);

   logic [STEP_WIDTH-1:0]     divisor_ff, divisor_in;
   logic [STEP_WIDTH-1:0]     rem_ff, rem_in;
   logic [DIVIDEND_WIDTH-1:0] quo_ff, quo_in;
   logic [DIV_CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [STEP_WIDTH:0]       trial;
   logic [STEP_WIDTH:0]       trial_sub;
   logic                      fits;

   always_comb begin
      trial     = {rem_ff, quo_ff[DIVIDEND_WIDTH-1]};
      trial_sub = trial - {1'b0, divisor_ff};
      fits      = (trial >= {1'b0, divisor_ff});

      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_start) begin
         divisor_in = div_divisor;
         rem_in     = '0;
         quo_in     = div_dividend;
         cnt_in     = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[STEP_WIDTH-1:0] : trial[STEP_WIDTH-1:0];
         quo_in = {quo_ff[DIVIDEND_WIDTH-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
   end

   assign div_quot      = quo_ff;
   assign div_stat.busy = busy_ff;
   assign div_stat.done = done_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pid_controller_clamped.sv =====
// Top level of the clamped fixed-point PID controller: sequencer, state and
// configuration registers. Depends on pcc_pkg, pcc_mul and pcc_div.
`timescale 1ns / 1ps
`default_nettype none

// Positional PID step with a clamped integral. Each request transfer brings
// a setpoint, a measured sample (both signed integers) and a time step in
// unsigned Q0.16 seconds; each produces exactly one response transfer with
// the clamped drive and two saturation flags. One item is worked on at a
// time, and the request side stalls until the sequencer is idle again. The
// products are formed by one shared shift-add multiplier that retires one
// multiplier bit per cycle, and the derivative quotient by a restoring
// divider, one bit per cycle, that runs alongside the first products. An
// item needs four products when the time step is nonzero and the
// controller is primed, three on the first timed step and two with a
// zero time step (no integral growth and no derivative product). The next
// request can be taken in the same cycle in which the result is shown.
// A finished result sits in an output register; the next request can be
// taken while it waits, and the sequencer only holds at its last step if
// the previous result has still not been transferred. Limit pairs written
// in reverse order are swapped at use. Configuration is written through a
// plain write port and must only be written while the block is idle.

module pid_controller_clamped
   import pcc_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,

   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [SAMPLE_WIDTH-1:0]     req_setpoint,
   input  wire logic [SAMPLE_WIDTH-1:0]     req_measured,
   input  wire logic [STEP_WIDTH-1:0]       req_step_time,

   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [SAMPLE_WIDTH-1:0]     rsp_drive,
   output logic                             rsp_drive_clamped,
   output logic                             rsp_accum_clamped,

   input  wire logic                        csr_wr_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]   csr_wdata
);

   // Configuration registers.
   logic [GAIN_WIDTH-1:0]   gain_prop_ff, gain_integ_ff, gain_deriv_ff;
   logic [SAMPLE_WIDTH-1:0] drive_lower_ff, drive_upper_ff;
   logic [ACCUM_WIDTH-1:0]  accum_lower_ff, accum_upper_ff;

   // Limits in their proper order.
   logic [SAMPLE_WIDTH-1:0] drive_lo, drive_hi;
   logic [ACCUM_WIDTH-1:0]  acc_lo, acc_hi;

   // Sequencer and per-item registers.
   pid_state_type          state_ff, state_in;
   logic [ERR_WIDTH-1:0]   err_ff, err_in;
   logic [STEP_WIDTH-1:0]  step_ff, step_in;
   logic                   deriv_on_ff, deriv_on_in;
   logic                   neg_ff, neg_in;
   logic                   aflag_ff, aflag_in;
   logic [TOTAL_WIDTH-1:0] total_ff, total_in;
   logic [QUOT_WIDTH-1:0]  q_ff, q_in;

   // Controller state that persists between items.
   logic [ACCUM_WIDTH-1:0] accumulator_ff, accumulator_in;
   logic [ERR_WIDTH-1:0]   last_error_ff, last_error_in;
   logic                   primed_ff, primed_in;

   // Response register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0] drive_ff, drive_in;
   logic                    dclamp_ff, dclamp_in;
   logic                    aclamp_ff, aclamp_in;
   logic                    load_rsp;

   // Serial units.
   logic                      mul_start;
   logic [MCAND_WIDTH-1:0]    mul_mcand;
   logic [MPLIER_WIDTH-1:0]   mul_mplier;
   logic [PROD_WIDTH-1:0]     mul_prod;
   unit_stat_type             mul_stat;
   logic                      div_start;
   logic [DIVIDEND_WIDTH-1:0] div_dividend;
   logic [DIVIDEND_WIDTH-1:0] div_quot;
   unit_stat_type             div_stat;

   // Datapath helpers.
   logic                      req_accept;
   logic                      step_nz;
   logic [DIFF_WIDTH-1:0]     diff;
   logic [DIFF_WIDTH-1:0]     diff_neg;
   logic [MAG_WIDTH-1:0]      diff_mag;
   logic [ACCUM_WIDTH-1:0]    pre_acc;
   logic                      pre_flag;
   logic [INC_WIDTH:0]        inc_sum;
   logic [INC_WIDTH:0]        inc_lo_ext, inc_hi_ext;
   logic [ACCUM_WIDTH-1:0]    inc_acc;
   logic                      inc_flag;
   logic                      quot_big;
   logic [DERIV_WIDTH-1:0]    deriv_sat;
   logic [SAT_WIDTH-1:0]      sat_sum;
   logic                      sum_ovf;
   logic [QUOT_WIDTH-1:0]     q_lo_ext, q_hi_ext;
   logic                      q_below, q_above;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff   <= '0;
         gain_integ_ff  <= '0;
         gain_deriv_ff  <= '0;
         drive_lower_ff <= DRIVE_LOWER_RESET;
         drive_upper_ff <= DRIVE_UPPER_RESET;
         accum_lower_ff <= ACCUM_LOWER_RESET;
         accum_upper_ff <= ACCUM_UPPER_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_PROP:   gain_prop_ff   <= csr_wdata[GAIN_WIDTH-1:0];
            CSR_GAIN_INTEG:  gain_integ_ff  <= csr_wdata[GAIN_WIDTH-1:0];
            CSR_GAIN_DERIV:  gain_deriv_ff  <= csr_wdata[GAIN_WIDTH-1:0];
            CSR_DRIVE_LOWER: drive_lower_ff <= csr_wdata[SAMPLE_WIDTH-1:0];
            CSR_DRIVE_UPPER: drive_upper_ff <= csr_wdata[SAMPLE_WIDTH-1:0];
            CSR_ACCUM_LOWER: accum_lower_ff <= csr_wdata[ACCUM_WIDTH-1:0];
            CSR_ACCUM_UPPER: accum_upper_ff <= csr_wdata[ACCUM_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // A limit pair written in reverse order is used swapped.
   always_comb begin
      if ($signed(drive_lower_ff) > $signed(drive_upper_ff)) begin
         drive_lo = drive_upper_ff;
         drive_hi = drive_lower_ff;
      end else begin
         drive_lo = drive_lower_ff;
         drive_hi = drive_upper_ff;
      end
      if ($signed(accum_lower_ff) > $signed(accum_upper_ff)) begin
         acc_lo = accum_upper_ff;
         acc_hi = accum_lower_ff;
      end else begin
         acc_lo = accum_lower_ff;
         acc_hi = accum_upper_ff;
      end
   end

   // Arithmetic that the sequencer steps pick from.
   always_comb begin
      step_nz = (step_ff != '0);

      // Change in error and its magnitude, scaled by one second for the divider.
      diff         = {err_ff[ERR_WIDTH-1], err_ff} - {last_error_ff[ERR_WIDTH-1], last_error_ff};
      diff_neg     = '0 - diff;
      diff_mag     = diff[DIFF_WIDTH-1] ? diff_neg[MAG_WIDTH-1:0] : diff[MAG_WIDTH-1:0];
      div_dividend = {diff_mag, {FRAC_BITS{1'b0}}};

      // Integral clamped to the current limits before it grows.
      pre_acc  = accumulator_ff;
      pre_flag = 1'b0;
      if ($signed(accumulator_ff) > $signed(acc_hi)) begin
         pre_acc  = acc_hi;
         pre_flag = 1'b1;
      end else if ($signed(accumulator_ff) < $signed(acc_lo)) begin
         pre_acc  = acc_lo;
         pre_flag = 1'b1;
      end

      // Integral grown by error times time step, then clamped again.
      inc_sum    = {{2{accumulator_ff[ACCUM_WIDTH-1]}}, accumulator_ff}
                 + {mul_prod[INC_WIDTH-1], mul_prod[INC_WIDTH-1:0]};
      inc_lo_ext = {{2{acc_lo[ACCUM_WIDTH-1]}}, acc_lo};
      inc_hi_ext = {{2{acc_hi[ACCUM_WIDTH-1]}}, acc_hi};
      inc_acc    = inc_sum[ACCUM_WIDTH-1:0];
      inc_flag   = 1'b0;
      if ($signed(inc_sum) > $signed(inc_hi_ext)) begin
         inc_acc  = acc_hi;
         inc_flag = 1'b1;
      end else if ($signed(inc_sum) < $signed(inc_lo_ext)) begin
         inc_acc  = acc_lo;
         inc_flag = 1'b1;
      end

      // Signed derivative from the quotient magnitude, saturated to 32 bits.
      quot_big = |div_quot[DIVIDEND_WIDTH-1:DERIV_WIDTH-1];
      if (neg_ff) begin
         deriv_sat = quot_big ? {1'b1, {(DERIV_WIDTH-1){1'b0}}}
                              : ('0 - div_quot[DERIV_WIDTH-1:0]);
      end else begin
         deriv_sat = quot_big ? {1'b0, {(DERIV_WIDTH-1){1'b1}}}
                              : div_quot[DERIV_WIDTH-1:0];
      end

      // Sum saturated to 64 bits, then truncated toward zero to an integer.
      sum_ovf = (total_ff[TOTAL_WIDTH-1:SAT_WIDTH-1] != '0)
             && (total_ff[TOTAL_WIDTH-1:SAT_WIDTH-1] != '1);
      if (sum_ovf) begin
         sat_sum = total_ff[TOTAL_WIDTH-1] ? {1'b1, {(SAT_WIDTH-1){1'b0}}}
                                           : {1'b0, {(SAT_WIDTH-1){1'b1}}};
      end else begin
         sat_sum = total_ff[SAT_WIDTH-1:0];
      end

      // Output limit compare on the integer part.
      q_lo_ext = {{(QUOT_WIDTH-SAMPLE_WIDTH){drive_lo[SAMPLE_WIDTH-1]}}, drive_lo};
      q_hi_ext = {{(QUOT_WIDTH-SAMPLE_WIDTH){drive_hi[SAMPLE_WIDTH-1]}}, drive_hi};
      q_below  = $signed(q_ff) < $signed(q_lo_ext);
      q_above  = $signed(q_ff) > $signed(q_hi_ext);
   end

   // Sequencer: next state, unit commands and register updates.
   always_comb begin
      state_in       = state_ff;
      err_in         = err_ff;
      step_in        = step_ff;
      deriv_on_in    = deriv_on_ff;
      neg_in         = neg_ff;
      aflag_in       = aflag_ff;
      total_in       = total_ff;
      q_in           = q_ff;
      accumulator_in = accumulator_ff;
      last_error_in  = last_error_ff;
      primed_in      = primed_ff;
      mul_start      = 1'b0;
      mul_mcand      = '0;
      mul_mplier     = '0;
      div_start      = 1'b0;
      load_rsp       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               err_in   = {req_setpoint[SAMPLE_WIDTH-1], req_setpoint}
                        - {req_measured[SAMPLE_WIDTH-1], req_measured};
               step_in  = req_step_time;
               state_in = ST_PRE;
            end
         end

         ST_PRE: begin
            accumulator_in = pre_acc;
            aflag_in       = pre_flag;
            last_error_in  = err_ff;
            neg_in         = diff[DIFF_WIDTH-1];
            deriv_on_in    = step_nz && primed_ff;
            div_start      = step_nz && primed_ff;
            if (step_nz) begin
               primed_in = 1'b1;
            end
            mul_start = 1'b1;
            if (step_nz) begin
               // Integral increment: error times time step.
               mul_mcand  = {{(MCAND_WIDTH-ERR_WIDTH){err_ff[ERR_WIDTH-1]}}, err_ff};
               mul_mplier = {{(MPLIER_WIDTH-STEP_WIDTH){1'b0}}, step_ff};
               state_in   = ST_INC;
            end else begin
               mul_mcand  = {{(MCAND_WIDTH-GAIN_WIDTH){gain_prop_ff[GAIN_WIDTH-1]}},
                             gain_prop_ff};
               mul_mplier = {{(MPLIER_WIDTH-ERR_WIDTH){err_ff[ERR_WIDTH-1]}}, err_ff};
               state_in   = ST_PROP;
            end
         end

         ST_INC: begin
            if (mul_stat.done) begin
               accumulator_in = inc_acc;
               aflag_in       = aflag_ff | inc_flag;
               mul_start      = 1'b1;
               mul_mcand      = {{(MCAND_WIDTH-GAIN_WIDTH){gain_prop_ff[GAIN_WIDTH-1]}},
                                 gain_prop_ff};
               mul_mplier     = {{(MPLIER_WIDTH-ERR_WIDTH){err_ff[ERR_WIDTH-1]}}, err_ff};
               state_in       = ST_PROP;
            end
         end

         ST_PROP: begin
            if (mul_stat.done) begin
               total_in   = {{(TOTAL_WIDTH-PROP_WIDTH){mul_prod[PROP_WIDTH-1]}},
                             mul_prod[PROP_WIDTH-1:0]};
               // Integral term: full product, floored to Q.16.
               mul_start  = 1'b1;
               mul_mcand  = accumulator_ff;
               mul_mplier = gain_integ_ff;
               state_in   = ST_INTEG;
            end
         end

         ST_INTEG: begin
            if (mul_stat.done) begin
               total_in = total_ff
                        + {{(TOTAL_WIDTH-SAT_WIDTH){mul_prod[PROD_WIDTH-1]}},
                           mul_prod[PROD_WIDTH-1:FRAC_BITS]};
               state_in = deriv_on_ff ? ST_DWAIT : ST_ROUND;
            end
         end

         ST_DWAIT: begin
            if (!div_stat.busy) begin
               mul_start  = 1'b1;
               mul_mcand  = {{(MCAND_WIDTH-DERIV_WIDTH){deriv_sat[DERIV_WIDTH-1]}}, deriv_sat};
               mul_mplier = gain_deriv_ff;
               state_in   = ST_DERIV;
            end
         end

         ST_DERIV: begin
            if (mul_stat.done) begin
               total_in = total_ff
                        + {{(TOTAL_WIDTH-SAT_WIDTH){mul_prod[SAT_WIDTH-1]}},
                           mul_prod[SAT_WIDTH-1:0]};
               state_in = ST_ROUND;
            end
         end

         ST_ROUND: begin
            // Negative values with a fraction move up by one to truncate
            // toward zero.
            q_in     = sat_sum[SAT_WIDTH-1:FRAC_BITS]
                     + {{(QUOT_WIDTH-1){1'b0}},
                        (sat_sum[SAT_WIDTH-1] && (sat_sum[FRAC_BITS-1:0] != '0))};
            state_in = ST_LIMIT;
         end

         ST_LIMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register: loads the clamped drive, holds while stalled.
   always_comb begin
      drive_in  = drive_ff;
      dclamp_in = dclamp_ff;
      aclamp_in = aclamp_ff;
      if (load_rsp) begin
         if (q_above) begin
            drive_in = drive_hi;
         end else if (q_below) begin
            drive_in = drive_lo;
         end else begin
            drive_in = q_ff[SAMPLE_WIDTH-1:0];
         end
         dclamp_in = q_above || q_below;
         aclamp_in = aflag_ff;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         accumulator_ff <= '0;
         last_error_ff  <= '0;
         primed_ff      <= 1'b0;
      end else begin
         rsp_valid_ff   <= rsp_valid_in;
         accumulator_ff <= accumulator_in;
         last_error_ff  <= last_error_in;
         primed_ff      <= primed_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff      <= err_in;
      step_ff     <= step_in;
      deriv_on_ff <= deriv_on_in;
      neg_ff      <= neg_in;
      aflag_ff    <= aflag_in;
      total_ff    <= total_in;
      q_ff        <= q_in;
      drive_ff    <= drive_in;
      dclamp_ff   <= dclamp_in;
      aclamp_ff   <= aclamp_in;
   end

   pcc_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .mul_start  (mul_start),
      .mul_mcand  (mul_mcand),
      .mul_mplier (mul_mplier),
      .mul_prod   (mul_prod),
      .mul_stat   (mul_stat)
   );

   pcc_div u_div (
      .clock        (clock),
      .reset        (reset),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (step_ff),
      .div_quot     (div_quot),
      .div_stat     (div_stat)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive         = drive_ff;
   assign rsp_drive_clamped = dclamp_ff;
   assign rsp_accum_clamped = aclamp_ff;

   // The shared multiplier is never restarted while it is still stepping.
   a_mul_free: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_stat.busy)
      else $error("multiplier started while busy");

   // The divider is never restarted while it is still stepping.
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   // A finished result that finds the output free is shown next cycle and
   // the sequencer is back at idle.
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LIMIT && !(rsp_valid_ff && rsp_stall))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not loaded into the response register");

endmodule

`default_nettype wire

// ===== tb/sv/pid_controller_clamped_tb.sv =====
// Self-checking testbench for the clamped fixed-point PID controller.
// Depends on pcc_pkg and the pid_controller_clamped RTL; reads no files.
// A scoreboard class predicts each response and checks it on transfer.
`timescale 1ns / 1ps

module pid_controller_clamped_tb;
   import pcc_pkg::*;

   // Clock period is 12 ns. The watchdog limit is many times the longest
   // quiet stretch of a correct run: one whole item, plus the longest
   // sender gap and the longest receiver stall.
   localparam int HALF_PERIOD   = 6;
   localparam int STALL_LIMIT   = 4000;
   localparam int TAIL_CYCLES   = 200;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 163;

   // The block has seven registers. Index 7 is left unmapped, and writes
   // to it must be ignored.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INDEX_UNMAPPED = 3'd7;

   localparam longint GAIN_ONE    = longint'(1) <<< FRAC_BITS;
   localparam longint GAIN_MAX    = 64'sh7FFF_FFFF;
   localparam longint GAIN_MIN    = -GAIN_MAX - 1;
   localparam longint DRIVE_FLOOR = longint'($signed(DRIVE_LOWER_RESET));
   localparam longint DRIVE_CEIL  = longint'($signed(DRIVE_UPPER_RESET));
   localparam longint ACCUM_FLOOR = longint'($signed(ACCUM_LOWER_RESET));
   localparam longint ACCUM_CEIL  = longint'($signed(ACCUM_UPPER_RESET));

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [SAMPLE_WIDTH-1:0]    req_setpoint;
   logic [SAMPLE_WIDTH-1:0]    req_measured;
   logic [STEP_WIDTH-1:0]      req_step_time;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [SAMPLE_WIDTH-1:0]    rsp_drive;
   logic                       rsp_drive_clamped;
   logic                       rsp_accum_clamped;
   logic                       csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;

   // When set, neither side inserts gaps or stalls, so each item is offered
   // as soon as the last one is taken, for a whole phase.
   bit steady;
   int settings_used;

   // The tracking stimulus follows a simple plant that drifts toward a
   // target. This keeps the error small, so the drive is often unclamped.
   int target;
   int plant;

   pid_controller_clamped DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_setpoint      (req_setpoint),
      .req_measured      (req_measured),
      .req_step_time     (req_step_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_drive         (rsp_drive),
      .rsp_drive_clamped (rsp_drive_clamped),
      .rsp_accum_clamped (rsp_accum_clamped),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] drive;
      logic                    drive_clamped;
      logic                    accum_clamped;
   } drive_result_type;

   // The scoreboard keeps its own copy of the registers and of the
   // controller state. It works out the drive for each request transfer
   // and queues it until the matching response transfer arrives.
   class pid_drive_scoreboard_type;
      localparam longint DERIV_MAX = 64'sh7FFF_FFFF;
      localparam longint DERIV_MIN = -DERIV_MAX - 1;
      localparam longint SUM_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
      localparam longint SUM_MIN   = -SUM_MAX - 1;

      longint gain_p, gain_i, gain_d;
      longint drive_lo, drive_hi, integ_lo, integ_hi;
      logic [ACCUM_WIDTH-1:0] integral;
      logic [ERR_WIDTH-1:0]   prev_error;
      bit primed;
      drive_result_type pending_drives[$];
      int mismatches, requests, responses, drive_clamps, integ_clamps;

      function new();
         gain_p = 0;
         gain_i = 0;
         gain_d = 0;
         drive_lo = longint'($signed(DRIVE_LOWER_RESET));
         drive_hi = longint'($signed(DRIVE_UPPER_RESET));
         integ_lo = longint'($signed(ACCUM_LOWER_RESET));
         integ_hi = longint'($signed(ACCUM_UPPER_RESET));
         integral = '0;
         prev_error = '0;
         primed = 0;
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      function longint add_sat(longint a, longint b);
         longint s;
         s = a + b;
         if (a >= 0 && b >= 0 && s < 0) return SUM_MAX;
         if (a < 0 && b < 0 && s >= 0) return SUM_MIN;
         return s;
      endfunction

      // Only the low bits that belong to a register are kept. Writes to an
      // unmapped index fall through the case and change nothing.
      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] data);
         case (idx)
            CSR_GAIN_PROP:   gain_p   = longint'($signed(data[GAIN_WIDTH-1:0]));
            CSR_GAIN_INTEG:  gain_i   = longint'($signed(data[GAIN_WIDTH-1:0]));
            CSR_GAIN_DERIV:  gain_d   = longint'($signed(data[GAIN_WIDTH-1:0]));
            CSR_DRIVE_LOWER: drive_lo = longint'($signed(data[SAMPLE_WIDTH-1:0]));
            CSR_DRIVE_UPPER: drive_hi = longint'($signed(data[SAMPLE_WIDTH-1:0]));
            CSR_ACCUM_LOWER: integ_lo = longint'($signed(data[ACCUM_WIDTH-1:0]));
            CSR_ACCUM_UPPER: integ_hi = longint'($signed(data[ACCUM_WIDTH-1:0]));
            default: ;
         endcase
      endfunction

      function void note_request(logic [SAMPLE_WIDTH-1:0] setpoint,
                                 logic [SAMPLE_WIDTH-1:0] measured,
                                 logic [STEP_WIDTH-1:0] step_time);
         longint err, step_len, acc, bounded, deriv, whole, frac, sum, q, qc;
         longint lo_d, hi_d, lo_a, hi_a;
         bit integ_hit;
         drive_result_type want;
         err = longint'($signed(setpoint)) - longint'($signed(measured));
         step_len = step_time;
         lo_d = drive_lo;
         hi_d = drive_hi;
         if (lo_d > hi_d) begin
            lo_d = drive_hi;
            hi_d = drive_lo;
         end
         lo_a = integ_lo;
         hi_a = integ_hi;
         if (lo_a > hi_a) begin
            lo_a = integ_hi;
            hi_a = integ_lo;
         end
         deriv = 0;
         integ_hit = 0;

         // The integral is clamped to the current limits even on a zero
         // time step, since the limits may have moved since the last step.
         acc = longint'($signed(integral));
         bounded = clip(acc, lo_a, hi_a);
         if (bounded != acc) integ_hit = 1;
         acc = bounded;

         if (step_len != 0) begin
            acc = acc + err * step_len;
            bounded = clip(acc, lo_a, hi_a);
            if (bounded != acc) integ_hit = 1;
            acc = bounded;
            // The derivative is left at zero on the first timed step.
            if (primed) begin
               deriv = ((err - longint'($signed(prev_error))) <<< FRAC_BITS) / step_len;
               deriv = clip(deriv, DERIV_MIN, DERIV_MAX);
            end else begin
               primed = 1;
            end
         end
         integral = acc[ACCUM_WIDTH-1:0];
         prev_error = err[ERR_WIDTH-1:0];

         // The integral term floors the fraction it drops, and the final
         // sum is truncated toward zero.
         whole = acc >>> FRAC_BITS;
         frac = acc - (whole <<< FRAC_BITS);
         sum = add_sat(gain_p * err, gain_i * whole + ((gain_i * frac) >>> FRAC_BITS));
         sum = add_sat(sum, gain_d * deriv);
         q = sum / (longint'(1) <<< FRAC_BITS);
         qc = clip(q, lo_d, hi_d);

         want.drive = qc[SAMPLE_WIDTH-1:0];
         want.drive_clamped = (qc != q);
         want.accum_clamped = integ_hit;
         if (want.drive_clamped) drive_clamps++;
         if (want.accum_clamped) integ_clamps++;
         requests++;
         pending_drives.push_back(want);
      endfunction

      function void check_response(logic [SAMPLE_WIDTH-1:0] drive, logic drive_clamped,
                                   logic accum_clamped);
         drive_result_type want;
         if (pending_drives.size() == 0) begin
            $display("%0t: response transfer with nothing expected, drive %0d",
                     $time, $signed(drive));
            mismatches++;
            return;
         end
         want = pending_drives.pop_front();
         responses++;
         if (drive !== want.drive) begin
            $display("%0t: drive mismatch, expected %0d, actual %0d",
                     $time, $signed(want.drive), $signed(drive));
            mismatches++;
         end
         if (drive_clamped !== want.drive_clamped) begin
            $display("%0t: drive_clamped mismatch, expected %0b, actual %0b",
                     $time, want.drive_clamped, drive_clamped);
            mismatches++;
         end
         if (accum_clamped !== want.accum_clamped) begin
            $display("%0t: accum_clamped mismatch, expected %0b, actual %0b",
                     $time, want.accum_clamped, accum_clamped);
            mismatches++;
         end
      endfunction
   endclass

   pid_drive_scoreboard_type sb;

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // Most gaps are zero or short. A few are long, so both sides idle
   // during every phase of the sequencer.
   function automatic int gap_len();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Both transfers are sampled at the clock edge. Inputs change only through
   // nonblocking assignments and the block's outputs come from registers, so
   // the values read here are the values from before the edge.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_request(req_setpoint, req_measured, req_step_time);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_drive, rsp_drive_clamped, rsp_accum_clamped);
   end

   // The receiver alternates short open windows with stalls of random
   // length. A stall can hold a finished result in the output register
   // while the next request is being worked on.
   initial begin
      int n;
      forever begin
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         n = gap_len();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
      end
   end

   // The watchdog counts cycles with no transfer and no register write.
   initial begin
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
            idle = 0;
         else
            idle++;
      end
      $display("%0t: no transfer for %0d cycles, giving up", $time, STALL_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // An optional gap comes first, and then the item is offered until a
   // transfer takes it. The valid stays high when the next item follows
   // with no gap, so valid gets one assignment per time step.
   task automatic send_item(logic [SAMPLE_WIDTH-1:0] sp, logic [SAMPLE_WIDTH-1:0] ms,
                            logic [STEP_WIDTH-1:0] dt);
      int n;
      n = gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_setpoint  <= sp;
      req_measured  <= ms;
      req_step_time <= dt;
      req_valid     <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // At least one edge passes before the queue is read, so the last request
   // transfer has been noted. Every item gives exactly one result, so an
   // empty queue means the block is idle. A few spare cycles follow anyway.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_drives.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Bits above the register's width carry random data, which the block
   // must ignore. The write enable stays high across a burst of writes.
   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] value);
      logic [CSR_DATA_WIDTH-1:0] junk, keep, data;
      int wide;
      case (idx)
         CSR_GAIN_PROP, CSR_GAIN_INTEG, CSR_GAIN_DERIV: wide = GAIN_WIDTH;
         CSR_DRIVE_LOWER, CSR_DRIVE_UPPER:              wide = SAMPLE_WIDTH;
         default:                                       wide = CSR_DATA_WIDTH;
      endcase
      junk = CSR_DATA_WIDTH'({$urandom(), $urandom()});
      keep = (wide >= CSR_DATA_WIDTH) ? '1 : ((48'd1 << wide) - 48'd1);
      data = (value & keep) | (junk & ~keep);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic configure(longint kp, longint ki, longint kd, longint dlo, longint dhi,
                            longint alo, longint ahi, bit stray);
      write_csr(CSR_GAIN_PROP, CSR_DATA_WIDTH'(kp));
      write_csr(CSR_GAIN_INTEG, CSR_DATA_WIDTH'(ki));
      write_csr(CSR_GAIN_DERIV, CSR_DATA_WIDTH'(kd));
      write_csr(CSR_DRIVE_LOWER, CSR_DATA_WIDTH'(dlo));
      write_csr(CSR_DRIVE_UPPER, CSR_DATA_WIDTH'(dhi));
      write_csr(CSR_ACCUM_LOWER, CSR_DATA_WIDTH'(alo));
      write_csr(CSR_ACCUM_UPPER, CSR_DATA_WIDTH'(ahi));
      if (stray) write_csr(CSR_INDEX_UNMAPPED, CSR_DATA_WIDTH'({$urandom(), $urandom()}));
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   // A gain is either full range, an extreme, zero, or a modest value. The
   // modest values keep the drive inside its limits often enough.
   function automatic longint pick_gain();
      longint v;
      case ($urandom_range(0, 5))
         0: begin
            v = $signed($urandom());
            return v;
         end
         1: begin
            v = $urandom_range(0, 1 << 19);
            return v - (1 << 18);
         end
         2: return 0;
         3: return $urandom_range(0, 1) ? GAIN_MAX : GAIN_MIN;
         default: begin
            v = $urandom_range(0, 1 << 13);
            return v - (1 << 12);
         end
      endcase
   endfunction

   function automatic longint pick_accum48();
      longint v;
      v = {$urandom(), $urandom()};
      return (v <<< 16) >>> 16;
   endfunction

   task automatic random_settings();
      longint dlo, dhi, alo, ahi, span;
      logic [SAMPLE_WIDTH-1:0] raw;
      case ($urandom_range(0, 3))
         0: begin
            dlo = DRIVE_FLOOR;
            dhi = DRIVE_CEIL;
         end
         1: begin
            raw = SAMPLE_WIDTH'($urandom());
            dlo = $signed(raw);
            raw = SAMPLE_WIDTH'($urandom());
            dhi = $signed(raw);
         end
         2: begin
            span = $urandom_range(0, 3000);
            dlo = $urandom_range(0, 1) ? -span : span;
            dhi = -dlo;
         end
         default: begin
            raw = SAMPLE_WIDTH'($urandom());
            dlo = $signed(raw);
            dhi = dlo;
         end
      endcase
      case ($urandom_range(0, 3))
         0: begin
            alo = ACCUM_FLOOR;
            ahi = ACCUM_CEIL;
         end
         1: begin
            span = longint'(1) <<< $urandom_range(16, 40);
            alo = -span;
            ahi = span - 1;
            if ($urandom_range(0, 1)) begin
               alo = span - 1;
               ahi = -span;
            end
         end
         2: begin
            alo = pick_accum48();
            ahi = pick_accum48();
         end
         default: begin
            span = $urandom_range(0, 1 << 30);
            alo = span - (1 << 29);
            span = $urandom_range(0, 1 << 24);
            ahi = alo + span;
         end
      endcase
      configure(pick_gain(), pick_gain(), pick_gain(), dlo, dhi, alo, ahi,
                $urandom_range(0, 3) == 0);
   endtask

   function automatic logic [SAMPLE_WIDTH-1:0] corner_sample();
      case ($urandom_range(0, 4))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'h0001;
      endcase
   endfunction

   task automatic random_request();
      logic [SAMPLE_WIDTH-1:0] sp, ms, raw;
      logic [STEP_WIDTH-1:0] dt;
      int noise;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            sp = SAMPLE_WIDTH'($urandom());
            ms = SAMPLE_WIDTH'($urandom());
         end
         3: begin
            sp = corner_sample();
            ms = corner_sample();
         end
         default: begin
            // The plant converges on the target, with a little noise, and
            // now and then the target jumps.
            if ($urandom_range(0, 31) == 0) begin
               raw = SAMPLE_WIDTH'($urandom());
               target = $signed(raw);
            end
            noise = $urandom_range(0, 64);
            plant = plant + (target - plant) / 8 + noise - 32;
            if (plant > 32767) plant = 32767;
            if (plant < -32768) plant = -32768;
            sp = target[SAMPLE_WIDTH-1:0];
            ms = plant[SAMPLE_WIDTH-1:0];
         end
      endcase
      case ($urandom_range(0, 19))
         0, 1: dt = '0;
         2: dt = 16'h0001;
         3: dt = 16'hFFFF;
         4, 5, 6, 7, 8, 9, 10, 11: dt = STEP_WIDTH'($urandom_range(1, 1024));
         default: dt = STEP_WIDTH'($urandom());
      endcase
      send_item(sp, ms, dt);
   endtask

   initial begin
      sb = new();
      steady = 0;
      settings_used = 0;
      target = 0;
      plant = 0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_setpoint  <= '0;
      req_measured  <= '0;
      req_step_time <= '0;
      csr_wr_en     <= 1'b0;
      csr_index     <= CSR_GAIN_PROP;
      csr_wdata     <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Plain gains and the reset limits. The first item has a zero time
      // step, so the controller is not yet primed. The second is the first
      // timed step and carries the largest error. The third carries the
      // smallest error over one time unit, so the derivative saturates.
      configure(GAIN_ONE, GAIN_ONE / 2, GAIN_ONE / 256, DRIVE_FLOOR, DRIVE_CEIL,
                ACCUM_FLOOR, ACCUM_CEIL, 1'b1);
      send_item(16'd100, 16'd40, 16'h0000);
      send_item(16'h7FFF, 16'h8000, 16'hFFFF);
      send_item(16'h8000, 16'h7FFF, 16'h0001);
      send_item(16'h0000, 16'h0000, 16'h0000);
      send_item(16'd5, 16'd3, 16'h8000);
      send_item(16'hFFFF, 16'h0000, 16'h0001);
      send_item(16'h0000, 16'h0000, 16'hFFFF);
      drain();

      // Both limit pairs are written in reverse order. The narrow integral
      // range also clips the integral carried over from before.
      configure(GAIN_MAX, GAIN_MIN, GAIN_MAX, 100, -100, 1 << 20, -(1 << 20), 1'b0);
      send_item(16'h0000, 16'h0000, 16'h0000);
      send_item(16'd1000, 16'h0000, 16'h1000);
      send_item(-16'sd1000, 16'h0000, 16'h1000);
      send_item(16'h7FFF, 16'h7FFF, 16'h0100);
      drain();

      // Equal output limits and an integral held at zero.
      configure(GAIN_MIN, GAIN_MAX, GAIN_MIN, 7, 7, 0, 0, 1'b1);
      send_item(16'h8000, 16'h7FFF, 16'hFFFF);
      send_item(16'd3, 16'd9, 16'h0040);
      send_item(16'h0000, 16'h0000, 16'h0000);
      drain();

      // Full-range limits, both pairs swapped.
      configure(-GAIN_ONE, 3 * GAIN_ONE, -GAIN_ONE / 16, DRIVE_CEIL, DRIVE_FLOOR,
                ACCUM_CEIL, ACCUM_FLOOR, 1'b0);
      send_item(16'h7FFF, 16'h8000, 16'h0001);
      send_item(16'h8000, 16'h7FFF, 16'hFFFF);
      send_item(16'd12, 16'hFFF0, 16'h0400);
      send_item(16'h0000, 16'h0001, 16'h0000);
      drain();

      // Random phases. Each phase has new register values. About a quarter
      // of the phases run with no gaps on either side.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         random_settings();
         steady = ($urandom_range(0, 3) == 0);
         repeat (PHASE_ITEMS) random_request();
         drain();
      end
      steady = 0;

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending_drives.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, sb.pending_drives.size());
         sb.mismatches++;
      end
      $display("Run summary: %0d requests under %0d register settings, %0d responses checked.",
               sb.requests, settings_used, sb.responses);
      $display("Drive hit its limits %0d times, the integral hit its limits %0d times.",
               sb.drive_clamps, sb.integ_clamps);
      if (sb.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
